// ===== rtl/fums_pkg.sv =====
`timescale 1ns / 1ps

package fums_pkg;

    localparam int CFG_ADDR_W = 5;

    // register indexes, paddr[4:2]
    localparam logic [2:0] REG_DEV_ADDR        = 3'd0;
    localparam logic [2:0] REG_IMAGE_BYTES     = 3'd1;
    localparam logic [2:0] REG_TIMEOUT_STARTUP = 3'd2;
    localparam logic [2:0] REG_TIMEOUT_ENTER   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_DATA    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TERM    = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_REBOOT  = 3'd6;
    localparam logic [2:0] REG_RETRY_LIMIT     = 3'd7;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MSG   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [2:0] MSG_STARTUP    = 3'd0;
    localparam logic [2:0] MSG_ENTER_RESP = 3'd1;
    localparam logic [2:0] MSG_DATA_RESP  = 3'd2;
    localparam logic [2:0] MSG_TERM_RESP  = 3'd3;

    localparam logic [1:0] SEND_REBOOT = 2'd0;
    localparam logic [1:0] SEND_ENTER  = 2'd1;
    localparam logic [1:0] SEND_DATA   = 2'd2;
    localparam logic [1:0] SEND_TERM   = 2'd3;

    localparam logic [7:0]  MASTER_ADDR = 8'd0;
    localparam logic [16:0] TICK_MAX    = 17'h1FFFF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STARTUP = 3'd1,
        PH_ENTER   = 3'd2,
        PH_DATA    = 3'd3,
        PH_TERM    = 3'd4,
        PH_REBOOT  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_BUSY  = 3'd1,
        ST_OK    = 3'd2,
        ST_RETRY = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [17:0] image_bytes;
        logic [15:0] timeout_startup;
        logic [15:0] timeout_enter;
        logic [15:0] timeout_data;
        logic [15:0] timeout_term;
        logic [15:0] timeout_reboot;
        logic [7:0]  retry_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        dev_addr:        8'd0,
        image_bytes:     18'd0,
        timeout_startup: 16'd2000,
        timeout_enter:   16'd10000,
        timeout_data:    16'd1000,
        timeout_term:    16'd1000,
        timeout_reboot:  16'd2000,
        retry_limit:     8'd10
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  msg_kind;
        logic [7:0]  sender_addr;
        logic [7:0]  receiver_addr;
        logic [15:0] echoed_word_addr;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_kind;
        logic [15:0] send_word_addr;
        logic [5:0]  send_bytes;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== rtl/fums_cfg.sv =====
`timescale 1ns / 1ps

module fums_cfg import fums_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_DEV_ADDR:        r_cfg.dev_addr        <= pwdata[7:0];
                REG_IMAGE_BYTES:     r_cfg.image_bytes     <= pwdata[17:0];
                REG_TIMEOUT_STARTUP: r_cfg.timeout_startup <= pwdata[15:0];
                REG_TIMEOUT_ENTER:   r_cfg.timeout_enter   <= pwdata[15:0];
                REG_TIMEOUT_DATA:    r_cfg.timeout_data    <= pwdata[15:0];
                REG_TIMEOUT_TERM:    r_cfg.timeout_term    <= pwdata[15:0];
                REG_TIMEOUT_REBOOT:  r_cfg.timeout_reboot  <= pwdata[15:0];
                REG_RETRY_LIMIT:     r_cfg.retry_limit     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DEV_ADDR:        prdata = 32'(r_cfg.dev_addr);
            REG_IMAGE_BYTES:     prdata = 32'(r_cfg.image_bytes);
            REG_TIMEOUT_STARTUP: prdata = 32'(r_cfg.timeout_startup);
            REG_TIMEOUT_ENTER:   prdata = 32'(r_cfg.timeout_enter);
            REG_TIMEOUT_DATA:    prdata = 32'(r_cfg.timeout_data);
            REG_TIMEOUT_TERM:    prdata = 32'(r_cfg.timeout_term);
            REG_TIMEOUT_REBOOT:  prdata = 32'(r_cfg.timeout_reboot);
            REG_RETRY_LIMIT:     prdata = 32'(r_cfg.retry_limit);
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/fums_core.sv =====
`timescale 1ns / 1ps

module fums_core import fums_pkg::*; #(
    parameter int PACKET_BYTES = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_go,
    input  t_item   i_item,
    output t_result o_res
);

    localparam int          BW   = $clog2(PACKET_BYTES + 1);
    localparam logic [16:0] STEP = 17'(PACKET_BYTES / 2);
    localparam logic [17:0] PKT  = 18'(PACKET_BYTES);

    t_phase      r_phase, n_phase;
    t_status     r_final, n_final;
    logic [16:0] r_elapsed, n_elapsed;
    logic [7:0]  r_retry, n_retry;
    logic [15:0] r_next_addr, n_next_addr;
    logic [15:0] r_last_addr, n_last_addr;
    logic        r_past_end, n_past_end;

    logic [BW-1:0] w_adv_bytes;
    logic [BW-1:0] w_resend_bytes;
    logic [16:0]   w_sum;
    logic [16:0]   w_tick_el;
    logic [15:0]   w_limit;
    logic          w_from_target;
    logic          w_to_me;

    // image bytes left at a word address, capped at one packet
    function automatic logic [BW-1:0] bytes_at(input logic [15:0] word,
                                               input logic [17:0] image);
        logic [17:0] off;
        logic [17:0] rem;
        off = {1'b0, word, 1'b0};
        rem = image - off;
        if (off >= image) begin
            bytes_at = '0;
        end else if (rem < PKT) begin
            bytes_at = BW'(rem);
        end else begin
            bytes_at = BW'(PKT);
        end
    endfunction

    assign w_adv_bytes    = r_past_end ? '0 : bytes_at(r_next_addr, i_cfg.image_bytes);
    assign w_resend_bytes = bytes_at(r_last_addr, i_cfg.image_bytes);
    assign w_sum          = {1'b0, r_next_addr} + STEP;
    assign w_tick_el      = (r_elapsed != TICK_MAX) ? r_elapsed + 17'd1 : r_elapsed;
    assign w_from_target  = (i_item.sender_addr == i_cfg.dev_addr);
    assign w_to_me        = (i_item.receiver_addr == MASTER_ADDR);

    always_comb begin
        case (r_phase)
            PH_STARTUP: w_limit = i_cfg.timeout_startup;
            PH_ENTER:   w_limit = i_cfg.timeout_enter;
            PH_DATA:    w_limit = i_cfg.timeout_data;
            PH_TERM:    w_limit = i_cfg.timeout_term;
            default:    w_limit = i_cfg.timeout_reboot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_final     <= ST_IDLE;
            r_elapsed   <= '0;
            r_retry     <= '0;
            r_next_addr <= '0;
            r_last_addr <= '0;
            r_past_end  <= 1'b0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_final     <= n_final;
            r_elapsed   <= n_elapsed;
            r_retry     <= n_retry;
            r_next_addr <= n_next_addr;
            r_last_addr <= n_last_addr;
            r_past_end  <= n_past_end;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_final     = r_final;
        n_elapsed   = r_elapsed;
        n_retry     = r_retry;
        n_next_addr = r_next_addr;
        n_last_addr = r_last_addr;
        n_past_end  = r_past_end;
        o_res       = '0;

        case (i_item.opcode)
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_elapsed = w_tick_el;
                    if (r_retry > i_cfg.retry_limit) begin
                        n_phase = PH_IDLE;
                        n_final = ST_RETRY;
                    end else if (w_tick_el > {1'b0, w_limit}) begin
                        n_elapsed = '0;
                        if (r_retry != 8'hFF) n_retry = r_retry + 8'd1;
                        o_res.send_valid = 1'b1;
                        case (r_phase)
                            PH_ENTER: o_res.send_kind = SEND_ENTER;
                            PH_TERM:  o_res.send_kind = SEND_TERM;
                            PH_DATA: begin
                                if (w_resend_bytes != '0) begin
                                    o_res.send_kind      = SEND_DATA;
                                    o_res.send_word_addr = r_last_addr;
                                    o_res.send_bytes     = 6'(w_resend_bytes);
                                end else begin
                                    o_res.send_valid = 1'b0;
                                end
                            end
                            default:  o_res.send_kind = SEND_REBOOT;
                        endcase
                    end
                end
            end
            OP_MSG: begin
                if (r_phase != PH_IDLE) begin
                    n_elapsed = '0;
                    case (r_phase)
                        PH_STARTUP: begin
                            if (i_item.msg_kind == MSG_STARTUP && w_from_target) begin
                                o_res.send_valid = 1'b1;
                                o_res.send_kind  = SEND_ENTER;
                                n_phase = PH_ENTER;
                                n_retry = '0;
                            end
                        end
                        PH_ENTER: begin
                            if (i_item.msg_kind == MSG_ENTER_RESP && w_to_me) begin
                                n_last_addr = r_next_addr;
                                n_next_addr = w_sum[15:0];
                                if (w_sum[16]) n_past_end = 1'b1;
                                if (w_adv_bytes == '0) begin
                                    n_phase = PH_IDLE;
                                    n_final = ST_EMPTY;
                                end else begin
                                    o_res.send_valid     = 1'b1;
                                    o_res.send_kind      = SEND_DATA;
                                    o_res.send_word_addr = r_next_addr;
                                    o_res.send_bytes     = 6'(w_adv_bytes);
                                    n_phase = PH_DATA;
                                    n_retry = '0;
                                end
                            end
                        end
                        PH_DATA: begin
                            if (i_item.msg_kind == MSG_DATA_RESP && w_to_me) begin
                                n_retry = '0;
                                if (i_item.echoed_word_addr == r_last_addr) begin
                                    n_last_addr = r_next_addr;
                                    n_next_addr = w_sum[15:0];
                                    if (w_sum[16]) n_past_end = 1'b1;
                                    o_res.send_valid = 1'b1;
                                    if (w_adv_bytes == '0) begin
                                        o_res.send_kind = SEND_TERM;
                                        n_phase = PH_TERM;
                                    end else begin
                                        o_res.send_kind      = SEND_DATA;
                                        o_res.send_word_addr = r_next_addr;
                                        o_res.send_bytes     = 6'(w_adv_bytes);
                                    end
                                end else if (w_resend_bytes != '0) begin
                                    o_res.send_valid     = 1'b1;
                                    o_res.send_kind      = SEND_DATA;
                                    o_res.send_word_addr = r_last_addr;
                                    o_res.send_bytes     = 6'(w_resend_bytes);
                                end
                            end
                        end
                        PH_TERM: begin
                            if (i_item.msg_kind == MSG_TERM_RESP && w_to_me) begin
                                o_res.send_valid = 1'b1;
                                o_res.send_kind  = SEND_REBOOT;
                                n_phase = PH_REBOOT;
                                n_retry = '0;
                            end
                        end
                        PH_REBOOT: begin
                            if (i_item.msg_kind == MSG_STARTUP && w_from_target) begin
                                n_phase = PH_IDLE;
                                n_final = ST_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase     = PH_STARTUP;
                    n_elapsed   = '0;
                    n_retry     = '0;
                    n_next_addr = '0;
                    n_last_addr = '0;
                    n_past_end  = 1'b0;
                    o_res.send_valid = 1'b1;
                    o_res.send_kind  = SEND_REBOOT;
                end
            end
            default: ;
        endcase

        o_res.status = (n_phase != PH_IDLE) ? ST_BUSY : n_final;
    end

endmodule

// ===== rtl/firmware_update_master_sequencer.sv =====
`timescale 1ns / 1ps

// Master-side firmware update sequencer. Each input word is a millisecond
// tick, a received bus message or a start command, and each one yields
// exactly one result word: an optional request to send (reboot, enter,
// data packet with word address and byte count, terminate) plus the run
// status. Words go through an input register, the next-state logic and a
// result register, so one word is taken every cycle unless the input side
// is stalled; a held result stalls the input side only once both registers
// are full. Configuration sits on an APB-style port at byte address
// 4*index and should only be written while no words are in flight.
module firmware_update_master_sequencer import fums_pkg::*; #(
    parameter int PACKET_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_opcode,
    input  logic [2:0]            i_msg_kind,
    input  logic [7:0]            i_sender_addr,
    input  logic [7:0]            i_receiver_addr,
    input  logic [15:0]           i_echoed_word_addr,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_send_valid,
    output logic [1:0]            o_send_kind,
    output logic [15:0]           o_send_word_addr,
    output logic [5:0]            o_send_bytes,
    output logic [2:0]            o_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_advance;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    fums_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the input word moves into the result register when that slot is free or is being read out
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;

    fums_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_go    (w_advance),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.opcode           <= i_opcode;
            r_in.msg_kind         <= i_msg_kind;
            r_in.sender_addr      <= i_sender_addr;
            r_in.receiver_addr    <= i_receiver_addr;
            r_in.echoed_word_addr <= i_echoed_word_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_send_valid     = r_out.send_valid;
    assign o_send_kind      = r_out.send_kind;
    assign o_send_word_addr = r_out.send_word_addr;
    assign o_send_bytes     = r_out.send_bytes;
    assign o_status         = r_out.status;

endmodule
